>>> rtl/core/obb_pkg.sv
// Shared widths, codes and types of the oriented box overlap tester.
package obb_pkg;

	localparam int COORD_BITS = 24;
	localparam int AXIS_BITS  = 16;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int LW     = 2 * AXIS_BITS + 1;
	localparam int DW     = LW + AXIS_BITS + 2;
	localparam int HALF   = (DW + 1) / 2;
	localparam int MA0    = (LW > AXIS_BITS) ? LW : AXIS_BITS;
	localparam int MA     = (MA0 > HALF + 1) ? MA0 : HALF + 1;
	localparam int MB     = (COORD_BITS + 1 > AXIS_BITS) ? COORD_BITS + 1 : AXIS_BITS;
	localparam int PW     = MA + MB;
	localparam int LHSW   = PW + 2;
	localparam int RHSW   = DW + COORD_BITS + 3;
	localparam int CW     = (LHSW + 1 > RHSW) ? LHSW + 1 : RHSW;

	localparam int IN_BITS = 4 * COORD_BITS + 3 * AXIS_BITS;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int USER_W  = 5;
	localparam int OUT_W   = 8;

	localparam logic [1:0] CMD_LD_CENTER = 2'd0;
	localparam logic [1:0] CMD_LD_AXIS   = 2'd1;
	localparam logic [1:0] CMD_TEST      = 2'd2;
	localparam logic [1:0] AXIS_SEL_MAX  = 2'd2;

	localparam logic [3:0] FIRST_CROSS = 4'd6;
	localparam logic [3:0] LAST_AXIS   = 4'd14;
	localparam logic [3:0] NO_SEP_AXIS = 4'd15;
	localparam logic [2:0] LAST_ROW    = 3'd5;
	localparam logic [2:0] ROW_B       = 3'd3;

	typedef enum logic [3:0] {
		OP_NONE, OP_LD_CENTER, OP_LD_AXIS, OP_SET_L, OP_SET_VA, OP_SET_VB,
		OP_CROSS, OP_DOTD, OP_DOTB, OP_EXT, OP_RESULT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] row;
		logic [1:0] comp;
		logic       first;
		logic       sub;
		logic       half;
		logic       res_overlap;
		logic [3:0] res_axis;
	} dp_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETL, ST_SETB, ST_CROSS, ST_DOTD, ST_DOTB, ST_WAITB,
		ST_EXT, ST_WAITC, ST_CMP
	} state_t;

endpackage

>>> rtl/core/obb_datapath.sv
// Box stores, shared multiplier and accumulators of the overlap tester.
module obb_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  obb_pkg::dp_cmd_t                      cmd,
	input  logic signed [obb_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [obb_pkg::COORD_BITS-1:0] pos_y,
	input  logic signed [obb_pkg::COORD_BITS-1:0] pos_z,
	input  logic signed [obb_pkg::AXIS_BITS-1:0]  dir_x,
	input  logic signed [obb_pkg::AXIS_BITS-1:0]  dir_y,
	input  logic signed [obb_pkg::AXIS_BITS-1:0]  dir_z,
	input  logic        [obb_pkg::COORD_BITS-1:0] extent,
	output logic                                  sep,
	output logic                                  overlap,
	output logic [3:0]                            separating_axis
);

	typedef struct packed {
		obb_pkg::op_t op;
		logic [1:0]   comp;
		logic         first;
		logic         sub;
		logic         half;
	} tag_t;

	logic signed [obb_pkg::COORD_BITS-1:0] center_q [2][3];
	logic signed [obb_pkg::AXIS_BITS-1:0]  axis_q [6][3];
	logic        [obb_pkg::COORD_BITS-1:0] extent_q [6];
	logic signed [obb_pkg::AXIS_BITS-1:0]  va_q [3];
	logic signed [obb_pkg::AXIS_BITS-1:0]  vb_q [3];
	logic signed [obb_pkg::LW-1:0]         l_q [3];
	logic signed [obb_pkg::DW-1:0]         dacc_q;
	logic signed [obb_pkg::LHSW-1:0]       lhs_q;
	logic        [obb_pkg::RHSW-1:0]       rhs_q;
	logic signed [obb_pkg::DIFF_W-1:0]     dv [3];
	logic signed [obb_pkg::MA-1:0]         op_a;
	logic signed [obb_pkg::MB-1:0]         op_b;
	logic signed [obb_pkg::PW-1:0]         prod_s1;
	tag_t                                  tag_s1;
	logic        [1:0]                     ia;
	logic        [1:0]                     ib;
	logic        [obb_pkg::DW-1:0]         dmag;
	logic        [obb_pkg::LHSW-1:0]       lmag;
	logic        [obb_pkg::RHSW-1:0]       ep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 2; b++) begin
				for (int c = 0; c < 3; c++) begin
					center_q[b][c] <= '0;
				end
			end
			for (int r = 0; r < 6; r++) begin
				extent_q[r] <= '0;
				for (int c = 0; c < 3; c++) begin
					axis_q[r][c] <= '0;
				end
			end
		end else begin
			case (cmd.op)
				obb_pkg::OP_LD_CENTER: begin
					center_q[cmd.row[0]][0] <= pos_x;
					center_q[cmd.row[0]][1] <= pos_y;
					center_q[cmd.row[0]][2] <= pos_z;
				end
				obb_pkg::OP_LD_AXIS: begin
					axis_q[cmd.row][0] <= dir_x;
					axis_q[cmd.row][1] <= dir_y;
					axis_q[cmd.row][2] <= dir_z;
					extent_q[cmd.row]  <= extent;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dv[c] = obb_pkg::DIFF_W'(center_q[0][c]) - obb_pkg::DIFF_W'(center_q[1][c]);
		end
		case (cmd.comp)
			2'd0: begin
				ia = cmd.sub ? 2'd2 : 2'd1;
				ib = cmd.sub ? 2'd1 : 2'd2;
			end
			2'd1: begin
				ia = cmd.sub ? 2'd0 : 2'd2;
				ib = cmd.sub ? 2'd2 : 2'd0;
			end
			default: begin
				ia = cmd.sub ? 2'd1 : 2'd0;
				ib = cmd.sub ? 2'd0 : 2'd1;
			end
		endcase
		dmag = dacc_q[obb_pkg::DW-1] ? $unsigned(-dacc_q) : $unsigned(dacc_q);
		op_a = '0;
		op_b = '0;
		case (cmd.op)
			obb_pkg::OP_CROSS: begin
				op_a = obb_pkg::MA'(va_q[ia]);
				op_b = obb_pkg::MB'(vb_q[ib]);
			end
			obb_pkg::OP_DOTD: begin
				op_a = obb_pkg::MA'(l_q[cmd.comp]);
				op_b = obb_pkg::MB'(dv[cmd.comp]);
			end
			obb_pkg::OP_DOTB: begin
				op_a = obb_pkg::MA'(l_q[cmd.comp]);
				op_b = obb_pkg::MB'(axis_q[cmd.row][cmd.comp]);
			end
			obb_pkg::OP_EXT: begin
				if (cmd.half) begin
					op_a = obb_pkg::MA'(dmag[obb_pkg::DW-1:obb_pkg::HALF]);
				end else begin
					op_a = obb_pkg::MA'(dmag[obb_pkg::HALF-1:0]);
				end
				op_b = obb_pkg::MB'(extent_q[cmd.row]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '{op: obb_pkg::OP_NONE, default: '0};
		end else begin
			tag_s1 <= '{op: cmd.op, comp: cmd.comp, first: cmd.first, sub: cmd.sub,
				half: cmd.half};
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign ep = obb_pkg::RHSW'(prod_s1[obb_pkg::HALF+obb_pkg::COORD_BITS-1:0]);

	always_ff @(posedge clk) begin
		case (cmd.op)
			obb_pkg::OP_SET_L: begin
				for (int c = 0; c < 3; c++) begin
					l_q[c] <= obb_pkg::LW'(axis_q[cmd.row][c]);
				end
			end
			obb_pkg::OP_SET_VA: begin
				va_q <= axis_q[cmd.row];
			end
			obb_pkg::OP_SET_VB: begin
				vb_q <= axis_q[cmd.row];
			end
			obb_pkg::OP_RESULT: begin
				overlap         <= cmd.res_overlap;
				separating_axis <= cmd.res_axis;
			end
			default: ;
		endcase
		case (tag_s1.op)
			obb_pkg::OP_CROSS: begin
				if (tag_s1.sub) begin
					l_q[tag_s1.comp] <= l_q[tag_s1.comp]
						- obb_pkg::LW'($signed(prod_s1[2*obb_pkg::AXIS_BITS-1:0]));
				end else begin
					l_q[tag_s1.comp] <= obb_pkg::LW'($signed(prod_s1[2*obb_pkg::AXIS_BITS-1:0]));
				end
			end
			obb_pkg::OP_DOTD: begin
				lhs_q <= (tag_s1.first ? '0 : lhs_q) + obb_pkg::LHSW'(prod_s1);
			end
			obb_pkg::OP_DOTB: begin
				dacc_q <= (tag_s1.first ? '0 : dacc_q)
					+ obb_pkg::DW'($signed(prod_s1[obb_pkg::LW+obb_pkg::AXIS_BITS-1:0]));
			end
			obb_pkg::OP_EXT: begin
				rhs_q <= (tag_s1.first ? '0 : rhs_q) + (tag_s1.half ? (ep << obb_pkg::HALF) : ep);
			end
			default: ;
		endcase
	end

	always_comb begin
		lmag = lhs_q[obb_pkg::LHSW-1] ? $unsigned(-lhs_q) : $unsigned(lhs_q);
		sep  = obb_pkg::CW'({lmag, 1'b0}) > obb_pkg::CW'(rhs_q);
	end

endmodule

>>> rtl/core/obb_ctrl.sv
// Sequencer that steps the overlap test through its candidate axes.
module obb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_cmd,
	input  logic             box_sel,
	input  logic [1:0]       axis_index,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             sep,
	output obb_pkg::dp_cmd_t cmd
);

	obb_pkg::state_t state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [2:0] j_q, j_d;
	logic [3:0] k_q, k_d;
	logic [1:0] p_q, p_d;
	logic [1:0] q_q, q_d;
	logic       out_valid_q, out_valid_d;

	assign in_ready  = (state_q == obb_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= obb_pkg::ST_IDLE;
			step_q      <= '0;
			j_q         <= '0;
			k_q         <= '0;
			p_q         <= '0;
			q_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			j_q         <= j_d;
			k_q         <= k_d;
			p_q         <= p_d;
			q_q         <= q_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		j_d         = j_q;
		k_d         = k_q;
		p_d         = p_q;
		q_d         = q_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '{op: obb_pkg::OP_NONE, default: '0};
		case (state_q)
			obb_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						obb_pkg::CMD_LD_CENTER: begin
							cmd.op  = obb_pkg::OP_LD_CENTER;
							cmd.row = {2'b00, box_sel};
						end
						obb_pkg::CMD_LD_AXIS: begin
							if (axis_index <= obb_pkg::AXIS_SEL_MAX) begin
								cmd.op  = obb_pkg::OP_LD_AXIS;
								cmd.row = box_sel ? obb_pkg::ROW_B + {1'b0, axis_index}
									: {1'b0, axis_index};
							end
						end
						obb_pkg::CMD_TEST: begin
							k_d     = '0;
							p_d     = '0;
							q_d     = '0;
							state_d = obb_pkg::ST_SETL;
						end
						default: ;
					endcase
				end
			end
			obb_pkg::ST_SETL: begin
				step_d = '0;
				if (k_q < obb_pkg::FIRST_CROSS) begin
					cmd.op  = obb_pkg::OP_SET_L;
					cmd.row = k_q[2:0];
					state_d = obb_pkg::ST_DOTD;
				end else begin
					cmd.op  = obb_pkg::OP_SET_VA;
					cmd.row = {1'b0, p_q};
					state_d = obb_pkg::ST_SETB;
				end
			end
			obb_pkg::ST_SETB: begin
				cmd.op  = obb_pkg::OP_SET_VB;
				cmd.row = obb_pkg::ROW_B + {1'b0, q_q};
				state_d = obb_pkg::ST_CROSS;
			end
			obb_pkg::ST_CROSS: begin
				cmd.op   = obb_pkg::OP_CROSS;
				cmd.comp = step_q[2:1];
				cmd.sub  = step_q[0];
				if (step_q == 3'd5) begin
					step_d  = '0;
					state_d = obb_pkg::ST_DOTD;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			obb_pkg::ST_DOTD: begin
				cmd.op    = obb_pkg::OP_DOTD;
				cmd.comp  = step_q[1:0];
				cmd.first = (step_q == 3'd0);
				if (step_q == 3'd2) begin
					step_d  = '0;
					j_d     = '0;
					state_d = obb_pkg::ST_DOTB;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			obb_pkg::ST_DOTB: begin
				cmd.op    = obb_pkg::OP_DOTB;
				cmd.row   = j_q;
				cmd.comp  = step_q[1:0];
				cmd.first = (step_q == 3'd0);
				if (step_q == 3'd2) begin
					step_d  = '0;
					state_d = obb_pkg::ST_WAITB;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			obb_pkg::ST_WAITB: begin
				state_d = obb_pkg::ST_EXT;
			end
			obb_pkg::ST_EXT: begin
				cmd.op    = obb_pkg::OP_EXT;
				cmd.row   = j_q;
				cmd.half  = step_q[0];
				cmd.first = (j_q == 3'd0) && (step_q == 3'd0);
				if (step_q == 3'd1) begin
					step_d = '0;
					if (j_q == obb_pkg::LAST_ROW) begin
						state_d = obb_pkg::ST_WAITC;
					end else begin
						j_d     = j_q + 3'd1;
						state_d = obb_pkg::ST_DOTB;
					end
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			obb_pkg::ST_WAITC: begin
				state_d = obb_pkg::ST_CMP;
			end
			obb_pkg::ST_CMP: begin
				if (sep || (k_q == obb_pkg::LAST_AXIS)) begin
					if (!out_valid_q || out_ready) begin
						cmd.op          = obb_pkg::OP_RESULT;
						cmd.res_overlap = !sep;
						cmd.res_axis    = sep ? k_q : obb_pkg::NO_SEP_AXIS;
						out_valid_d     = 1'b1;
						state_d         = obb_pkg::ST_IDLE;
					end
				end else begin
					k_d = k_q + 4'd1;
					if (k_q >= obb_pkg::FIRST_CROSS) begin
						if (q_q == 2'd2) begin
							q_d = '0;
							p_d = p_q + 2'd1;
						end else begin
							q_d = q_q + 2'd1;
						end
					end
					state_d = obb_pkg::ST_SETL;
				end
			end
			default: begin
				state_d = obb_pkg::ST_IDLE;
			end
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == obb_pkg::OP_RESULT) |-> (!out_valid_q || out_ready))
		else $error("Result written over an undelivered one.");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != obb_pkg::ST_IDLE) |-> (k_q <= obb_pkg::LAST_AXIS))
		else $error("Axis counter beyond the last candidate axis.");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obb_pkg::ST_DOTB || state_q == obb_pkg::ST_EXT) |-> (j_q <= obb_pkg::LAST_ROW))
		else $error("Box axis counter out of range.");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == obb_pkg::OP_RESULT) |=> (out_valid_q && state_q == obb_pkg::ST_IDLE))
		else $error("Result not presented after the test finished.");

endmodule

>>> rtl/core/obb_overlap_test_top.sv
// Top level of the oriented box overlap tester (separating axis test).
//
// The slave stream carries requests: tuser holds the command, the box and the
// local axis; tdata holds a center or an axis vector with its full extent.
// A load request writes one element and gives no result.
// A test request tries the three axes of box A, the three of box B and then
// the nine cross products, stopping at the first axis that separates.
// One shared multiplier, fed in turn by the controller, does all the work:
// for each axis it forms the cross product when there is one, then the dot
// product with the center difference, then for each of the six box axes a
// dot product and an extent product, and the two sums are then compared.
// The result then stands in the output register in the next cycle.
// Requests are taken only while no test is running; a waiting result does not
// block loads or the start of a new test, but a finished test holds until
// the earlier result has been taken.
// Reset clears all stored boxes to zero and empties the output register.
module obb_overlap_test_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, extent, from bit 0 up
	input  logic [obb_pkg::IN_W-1:0]    s_axis_tdata,
	// cmd, box_sel, axis_index
	input  logic [obb_pkg::USER_W-1:0]  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// overlap, separating_axis, then zero fill
	output logic [obb_pkg::OUT_W-1:0]   m_axis_tdata
);

	localparam int C = obb_pkg::COORD_BITS;
	localparam int A = obb_pkg::AXIS_BITS;

	obb_pkg::dp_cmd_t cmd;
	logic             sep;
	logic             overlap;
	logic [3:0]       separating_axis;

	obb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (s_axis_tuser[1:0]),
		.box_sel    (s_axis_tuser[2]),
		.axis_index (s_axis_tuser[4:3]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.sep        (sep),
		.cmd        (cmd)
	);

	obb_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.pos_x           (s_axis_tdata[C-1:0]),
		.pos_y           (s_axis_tdata[2*C-1:C]),
		.pos_z           (s_axis_tdata[3*C-1:2*C]),
		.dir_x           (s_axis_tdata[3*C+A-1:3*C]),
		.dir_y           (s_axis_tdata[3*C+2*A-1:3*C+A]),
		.dir_z           (s_axis_tdata[3*C+3*A-1:3*C+2*A]),
		.extent          (s_axis_tdata[4*C+3*A-1:3*C+3*A]),
		.sep             (sep),
		.overlap         (overlap),
		.separating_axis (separating_axis)
	);

	assign m_axis_tdata = obb_pkg::OUT_W'({separating_axis, overlap});

endmodule

>>> dv/obb_overlap_test_top_tb.sv
// Self-checking stream testbench for the oriented box overlap tester.
`timescale 1ns / 1ps

module obb_overlap_test_top_tb;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0]         cmd;
		logic               box;
		logic [1:0]         ax;
		logic signed [23:0] pos [3];
		logic signed [15:0] dir [3];
		logic [23:0]        ext;
	} request_t;

	typedef struct {
		logic       overlap;
		logic [3:0] axis;
	} verdict_t;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] AXIS_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 800;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [obb_pkg::IN_W-1:0]   s_axis_tdata;
	logic [obb_pkg::USER_W-1:0] s_axis_tuser;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [obb_pkg::OUT_W-1:0]  m_axis_tdata;

	obb_overlap_test_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	request_t           pending [$];
	request_t           on_bus;
	verdict_t           verdicts [$];
	logic signed [23:0] centre_copy [6];
	logic signed [15:0] axis_copy [18];
	logic [23:0]        extent_copy [6];
	int                 errors;
	int                 idle_cycles;
	bit                 taken;
	int                 gap_left;
	int                 burst_left;
	int                 stall_mode;
	int                 stall_phase;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic wide_t dot3(input wide_t l0, l1, l2, v0, v1, v2);
		return l0 * v0 + l1 * v1 + l2 * v2;
	endfunction

	function automatic wide_t magnitude(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [3:0] first_separating_axis();
		wide_t d [3];
		wide_t l [3];
		wide_t a [3];
		wide_t b [3];
		wide_t lhs;
		wide_t rhs;
		int    pa;
		int    pb;
		for (int c = 0; c < 3; c++)
			d[c] = wide_t'(centre_copy[c]) - wide_t'(centre_copy[3 + c]);
		for (int k = 0; k < 15; k++) begin
			if (k < 6) begin
				for (int c = 0; c < 3; c++)
					l[c] = wide_t'(axis_copy[(k / 3) * 9 + (k % 3) * 3 + c]);
			end else begin
				pa = ((k - 6) / 3) * 3;
				pb = 9 + ((k - 6) % 3) * 3;
				for (int c = 0; c < 3; c++) begin
					a[c] = wide_t'(axis_copy[pa + c]);
					b[c] = wide_t'(axis_copy[pb + c]);
				end
				l[0] = a[1] * b[2] - a[2] * b[1];
				l[1] = a[2] * b[0] - a[0] * b[2];
				l[2] = a[0] * b[1] - a[1] * b[0];
			end
			lhs = 2 * magnitude(dot3(l[0], l[1], l[2], d[0], d[1], d[2]));
			rhs = 0;
			for (int bx = 0; bx < 2; bx++)
				for (int i = 0; i < 3; i++) begin
					pa = bx * 9 + i * 3;
					rhs += magnitude(dot3(l[0], l[1], l[2], wide_t'(axis_copy[pa]),
						wide_t'(axis_copy[pa + 1]), wide_t'(axis_copy[pa + 2])))
						* wide_t'($signed({1'b0, extent_copy[bx * 3 + i]}));
				end
			if (lhs > rhs)
				return 4'(k);
		end
		return obb_pkg::NO_SEP_AXIS;
	endfunction

	task automatic apply_request(input request_t r);
		verdict_t v;
		if (r.cmd == obb_pkg::CMD_LD_CENTER) begin
			for (int c = 0; c < 3; c++)
				centre_copy[r.box * 3 + c] = r.pos[c];
		end else if (r.cmd == obb_pkg::CMD_LD_AXIS) begin
			if (r.ax <= obb_pkg::AXIS_SEL_MAX) begin
				for (int c = 0; c < 3; c++)
					axis_copy[r.box * 9 + r.ax * 3 + c] = r.dir[c];
				extent_copy[r.box * 3 + r.ax] = r.ext;
			end
		end else if (r.cmd == obb_pkg::CMD_TEST) begin
			v.axis = first_separating_axis();
			v.overlap = (v.axis == obb_pkg::NO_SEP_AXIS);
			verdicts.push_back(v);
		end
	endtask

	function automatic request_t blank_request(input logic [1:0] cmd);
		request_t r;
		r.cmd = cmd;
		r.box = 1'b0;
		r.ax = 2'd0;
		for (int c = 0; c < 3; c++) begin
			r.pos[c] = '0;
			r.dir[c] = '0;
		end
		r.ext = '0;
		return r;
	endfunction

	task automatic add_centre(input logic box, input int x, y, z);
		request_t r;
		r = blank_request(obb_pkg::CMD_LD_CENTER);
		r.box = box;
		r.pos[0] = 24'(x);
		r.pos[1] = 24'(y);
		r.pos[2] = 24'(z);
		pending.push_back(r);
	endtask

	task automatic add_axis(input logic box, input logic [1:0] ax, input int dx, dy, dz,
		input logic [23:0] e);
		request_t r;
		r = blank_request(obb_pkg::CMD_LD_AXIS);
		r.box = box;
		r.ax = ax;
		r.dir[0] = 16'(dx);
		r.dir[1] = 16'(dy);
		r.dir[2] = 16'(dz);
		r.ext = e;
		pending.push_back(r);
	endtask

	task automatic add_test();
		pending.push_back(blank_request(obb_pkg::CMD_TEST));
	endtask

	function automatic int rand_dir();
		return $urandom_range(32768) - 16384;
	endfunction

	function automatic int rand_coord(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic add_noise();
		request_t r;
		r = blank_request(2'($urandom_range(3)));
		r.box = 1'($urandom);
		r.ax = 2'($urandom_range(3));
		for (int c = 0; c < 3; c++) begin
			r.pos[c] = 24'($urandom);
			r.dir[c] = 16'(rand_dir());
		end
		r.ext = 24'($urandom);
		if ($urandom_range(1))
			r.cmd = CMD_SPARE;
		else if (r.cmd == obb_pkg::CMD_LD_AXIS && $urandom_range(1))
			r.ax = AXIS_SPARE;
		pending.push_back(r);
	endtask

	task automatic add_scene();
		int span;
		int style;
		int unit_perm [3];
		int p;
		int s;
		int v [3];
		span = ($urandom_range(3) == 0) ? 8388607 : ($urandom_range(1) ? 1000 : 200000);
		style = $urandom_range(2);
		for (int bx = 0; bx < 2; bx++) begin
			if ($urandom_range(7) != 0)
				add_centre(1'(bx), rand_coord(span), rand_coord(span), rand_coord(span));
			p = $urandom_range(2);
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(9) == 0)
					continue;
				if (style == 0) begin
					s = $urandom_range(1) ? 16384 : -16384;
					v = '{0, 0, 0};
					v[(p + i) % 3] = s;
				end else if (style == 1) begin
					v[0] = rand_dir() / 16;
					v[1] = rand_dir() / 16;
					v[2] = rand_dir() / 16;
				end else begin
					v[0] = rand_dir();
					v[1] = rand_dir();
					v[2] = rand_dir();
				end
				add_axis(1'(bx), 2'(i), v[0], v[1], v[2],
					24'($urandom_range((span > 8388607 / 2) ? 16777215 : 2 * span)));
				if ($urandom_range(15) == 0)
					add_noise();
			end
		end
		add_test();
		if ($urandom_range(5) == 0)
			add_test();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		errors = 0;
		for (int i = 0; i < 6; i++) begin
			centre_copy[i] = '0;
			extent_copy[i] = '0;
		end
		for (int i = 0; i < 18; i++)
			axis_copy[i] = '0;

		// Boxes from reset are all zero, so nothing separates.
		add_test();
		add_centre(1'b0, 8388607, -8388608, 0);
		add_centre(1'b1, -8388608, 8388607, 8388607);
		add_axis(1'b0, 2'd0, 16384, 0, 0, 24'd16777215);
		add_axis(1'b0, 2'd1, 0, -16384, 0, 24'd0);
		add_axis(1'b0, 2'd2, 0, 0, 16384, 24'd16777215);
		add_axis(1'b1, 2'd0, -16384, 0, 0, 24'd0);
		add_axis(1'b1, 2'd1, 0, 16384, 0, 24'd16777215);
		add_axis(1'b1, 2'd2, 16384, 16384, -16384, 24'd16777215);
		add_test();
		pending.push_back(blank_request(CMD_SPARE));
		add_axis(1'b0, AXIS_SPARE, 123, -456, 789, 24'd5);
		add_centre(1'b0, 0, 0, 0);
		add_centre(1'b1, 0, 0, 0);
		add_test();
		// Parallel axes give zero cross products, which never separate.
		add_centre(1'b1, 30, 40, -50);
		add_axis(1'b1, 2'd0, 16384, 0, 0, 24'd10);
		add_axis(1'b1, 2'd1, 0, 16384, 0, 24'd10);
		add_axis(1'b1, 2'd2, 0, 0, 16384, 24'd10);
		add_axis(1'b0, 2'd1, 0, 16384, 0, 24'd8);
		add_test();
		add_centre(1'b1, 3, 4, -5);
		add_test();

		while (pending.size() < 1900) begin
			if ($urandom_range(9) == 0)
				add_noise();
			else
				add_scene();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(pending.size() == 0 && !s_axis_tvalid && verdicts.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && verdicts.size() == 0) begin
			$display("obb_overlap_test_top regression: pass");
		end else begin
			$display("obb_overlap_test_top regression: fail");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || taken) begin
				taken = 1'b0;
				if (gap_left > 0 || pending.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end else begin
					on_bus = pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= {on_bus.ax, on_bus.box, on_bus.cmd};
					s_axis_tdata <= {on_bus.ext, on_bus.dir[2], on_bus.dir[1], on_bus.dir[0],
						on_bus.pos[2], on_bus.pos[1], on_bus.pos[0]};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(30);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end
				end
			end
			if (stall_phase == 0) begin
				stall_mode = $urandom_range(3);
				stall_phase = 64;
			end
			stall_phase--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom);
				2: m_axis_tready <= ((stall_phase % 8) < 3);
				default: m_axis_tready <= ($urandom_range(9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n) begin
			idle_cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				idle_cycles = 0;
				if (verdicts.size() == 0) begin
					errors++;
					$error("result %h with no test request outstanding", m_axis_tdata);
				end else begin
					v = verdicts.pop_front();
					if (m_axis_tdata[0] !== v.overlap) begin
						errors++;
						$error("overlap: expected %0d, got %0d", v.overlap, m_axis_tdata[0]);
					end
					if (m_axis_tdata[4:1] !== v.axis) begin
						errors++;
						$error("separating_axis: expected %0d, got %0d", v.axis,
							m_axis_tdata[4:1]);
					end
					if (m_axis_tdata[obb_pkg::OUT_W-1:5] !== '0) begin
						errors++;
						$error("zero fill: expected 0, got %h",
							m_axis_tdata[obb_pkg::OUT_W-1:5]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				idle_cycles = 0;
				taken = 1'b1;
				apply_request(on_bus);
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("obb_overlap_test_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		taken = 1'b0;
		idle_cycles = 0;
		gap_left = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_phase = 0;
	end

endmodule

>>> filelist.f
rtl/core/obb_pkg.sv
rtl/core/obb_datapath.sv
rtl/core/obb_ctrl.sv
rtl/core/obb_overlap_test_top.sv
dv/obb_overlap_test_top_tb.sv
